### design/nbz_pkg.sv
`timescale 1ns / 1ps

package nbz_pkg;

  localparam int unsigned SAMPLES_DEF = 200;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned NUM_REGS    = 8;

  typedef enum logic [2:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cfg_reg_e;

  localparam logic signed [COORD_W-1:0] P0_X_RST = 16'sd0;
  localparam logic signed [COORD_W-1:0] P0_Y_RST = 16'sd3200;
  localparam logic signed [COORD_W-1:0] P1_X_RST = 16'sd0;
  localparam logic signed [COORD_W-1:0] P1_Y_RST = 16'sd0;
  localparam logic signed [COORD_W-1:0] P2_X_RST = 16'sd4800;
  localparam logic signed [COORD_W-1:0] P2_Y_RST = 16'sd0;
  localparam logic signed [COORD_W-1:0] P3_X_RST = 16'sd4800;
  localparam logic signed [COORD_W-1:0] P3_Y_RST = 16'sd3200;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
  } query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic [INDEX_W-1:0]        near_index;
  } result_t;

  // bernstein weight j at t (Q0.16), rounded half up from Q0.48
  function automatic logic [WEIGHT_W-1:0] bz_weight(longint unsigned t, int unsigned j);
    longint unsigned u;
    longint unsigned p;
    u = 64'd65536 - t;
    case (j)
      0:       p = u * u * u;
      1:       p = 64'd3 * u * u * t;
      2:       p = 64'd3 * u * t * t;
      default: p = t * t * t;
    endcase
    return WEIGHT_W'((p + (64'd1 << 31)) >> 32);
  endfunction

endpackage

### design/nearest_point_on_cubic_bezier.sv
`timescale 1ns / 1ps

// result: done_o strobes once the last sample has left the pipeline and the sequencer returns to idle
// a new request is taken only while busy is low; the sample pipeline evaluates one k per cycle
// busy stays high from the accepted request until the done_o cycle, where it is already low
// the receiver cannot stall: done_o is a one-cycle strobe with res_o valid alongside
// reset: control clears, control points return to their default curve
module nearest_point_on_cubic_bezier
  import nbz_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  query_t               req_i,
  output logic                 done_o,
  output result_t              res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned PROD_W = 34;
  localparam int unsigned ACC_W  = 36;
  localparam int unsigned RND_W  = ACC_W - 16;
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * COORD_W;
  localparam int unsigned DIST_W = SQ_W + 1;
  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(SAMPLES - 1);

  // weight table, folded to constants
  logic [WEIGHT_W-1:0] w_tab [SAMPLES][4];

  for (genvar g = 0; g < SAMPLES; g++) begin : g_wtab
    localparam longint unsigned T = (longint'(g) * 65536 + SAMPLES / 2) / SAMPLES;
    for (genvar j = 0; j < 4; j++) begin : g_w
      assign w_tab[g][j] = bz_weight(T, j);
    end
  end

  // configuration registers
  logic signed [COORD_W-1:0] cfg_q [NUM_REGS];

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_P0_X] <= P0_X_RST;
      cfg_q[REG_P0_Y] <= P0_Y_RST;
      cfg_q[REG_P1_X] <= P1_X_RST;
      cfg_q[REG_P1_Y] <= P1_Y_RST;
      cfg_q[REG_P2_X] <= P2_X_RST;
      cfg_q[REG_P2_Y] <= P2_Y_RST;
      cfg_q[REG_P3_X] <= P3_X_RST;
      cfg_q[REG_P3_Y] <= P3_Y_RST;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_index_i[2:0]] <= $signed(cfg_data_i);
    end
  end

  // sequencer
  seq_state_e state_q, state_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic v1_q, v2_q, v3_q, v4_q;
  logic last1_q, last2_q, last3_q, last4_q;
  logic [IDX_W-1:0] k1_q, k2_q, k3_q, k4_q;
  logic done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (start) state_d = ST_RUN;
      end
      ST_RUN: begin
        k_d = k_q + 1'b1;
        if (k_q == K_LAST) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (v4_q && last4_q) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  query_t q_q;

  always_ff @(posedge clk_i) begin
    if (start && !busy) q_q <= req_i;
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_RUN);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: weight lookup
  logic [WEIGHT_W-1:0] w_q [4];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) w_q[i] <= w_tab[k_q][i];
    k1_q    <= k_q;
    last1_q <= (k_q == K_LAST);
  end

  // stage 2: weight times control point
  logic signed [PROD_W-1:0] px_q [4];
  logic signed [PROD_W-1:0] py_q [4];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      px_q[i] <= PROD_W'($signed({1'b0, w_q[i]}) * cfg_q[2*i]);
      py_q[i] <= PROD_W'($signed({1'b0, w_q[i]}) * cfg_q[2*i+1]);
    end
    k2_q    <= k1_q;
    last2_q <= last1_q;
  end

  // stage 3: sum, round half up to Q12.4, saturate
  function automatic logic signed [COORD_W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic signed [RND_W-1:0] r;
    sh = (acc + ACC_W'(32768)) >>> 16;
    r  = sh[RND_W-1:0];
    if (r > RND_W'(32767)) return 16'sh7fff;
    else if (r < -RND_W'(32768)) return 16'sh8000;
    else return r[COORD_W-1:0];
  endfunction

  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic signed [COORD_W-1:0] cx3_q, cy3_q;

  always_comb begin
    acc_x = '0;
    acc_y = '0;
    for (int i = 0; i < 4; i++) begin
      acc_x = acc_x + ACC_W'(px_q[i]);
      acc_y = acc_y + ACC_W'(py_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    cx3_q   <= round_sat(acc_x);
    cy3_q   <= round_sat(acc_y);
    k3_q    <= k2_q;
    last3_q <= last2_q;
  end

  // stage 4: squared offsets
  logic signed [DIFF_W-1:0] dx, dy;
  logic [SQ_W-1:0] sqx_q, sqy_q;
  logic signed [COORD_W-1:0] cx4_q, cy4_q;

  assign dx = DIFF_W'(q_q.query_x) - DIFF_W'(cx3_q);
  assign dy = DIFF_W'(q_q.query_y) - DIFF_W'(cy3_q);

  always_ff @(posedge clk_i) begin
    sqx_q   <= SQ_W'(dx * dx);
    sqy_q   <= SQ_W'(dy * dy);
    cx4_q   <= cx3_q;
    cy4_q   <= cy3_q;
    k4_q    <= k3_q;
    last4_q <= last3_q;
  end

  // stage 5: keep the earliest minimum
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_d_q;
  result_t best_q;
  result_t res_q;
  logic take;

  assign dist_sum = DIST_W'(sqx_q) + DIST_W'(sqy_q);
  assign take = v4_q && ((k4_q == '0) || (dist_sum < best_d_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_d_q          <= dist_sum;
      best_q.near_x     <= cx4_q;
      best_q.near_y     <= cy4_q;
      best_q.near_index <= INDEX_W'(k4_q);
    end
    if (v4_q && last4_q) begin
      if (take) begin
        res_q.near_x     <= cx4_q;
        res_q.near_y     <= cy4_q;
        res_q.near_index <= INDEX_W'(k4_q);
      end else begin
        res_q <= best_q;
      end
    end
  end

  assign res_o = res_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done strobe while still busy");

  a_start_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q && !v3_q && !v4_q))
    else $error("pipeline holds samples while idle");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.near_index <= INDEX_W'(SAMPLES - 1)))
    else $error("nearest index out of sample range");

  a_done_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v4_q && last4_q))
    else $error("done without last sample");

endmodule
